@@ rtl/adaptive_optimizer_update_top_assert.svh @@
// ---------------------------------------------------------------------------
// adaptive optimizer update assertion macros
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_OPTIMIZER_UPDATE_TOP_ASSERT_SVH
`define ADAPTIVE_OPTIMIZER_UPDATE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define AOU_ASSERT_IMPLIES(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define AOU_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define AOU_ASSERT_IMPLIES(lbl, a, b, msg)
`define AOU_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

@@ rtl/aou_pkg.sv @@
// ---------------------------------------------------------------------------
// aou_pkg
// shared types, widths and helpers of the adaptive optimizer update
// ---------------------------------------------------------------------------
package aou_pkg;

    localparam int IDX_W      = 12;
    localparam int VAL_W      = 32;
    localparam int LR_W       = 24;
    localparam int DEC_W      = 16;
    localparam int FRAC_W     = 24;
    localparam int ENTRIES    = 4096;
    localparam int WIDE_W     = 58;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int ROOT_W     = 28;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int NUM_W      = LR_W + VAL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPDATE_MODE   = 2'd0,
        REG_LEARNING_RATE = 2'd1,
        REG_FIRST_DECAY   = 2'd2,
        REG_SECOND_DECAY  = 2'd3
    } cfg_reg_t;

    localparam logic              RST_UPDATE_MODE   = 1'b1;
    localparam logic [LR_W-1:0]   RST_LEARNING_RATE = 24'd16777;
    localparam logic [DEC_W-1:0]  RST_FIRST_DECAY   = 16'd58982;
    localparam logic [DEC_W-1:0]  RST_SECOND_DECAY  = 16'd65470;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

    typedef struct packed {
        logic             update_mode;
        logic [LR_W-1:0]  learning_rate;
        logic [DEC_W-1:0] first_decay;
        logic [DEC_W-1:0] second_decay;
    } cfg_t;

    // one word between front and back
    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] weight;
        logic                    adaptive;
        logic signed [VAL_W-1:0] moment;
        logic signed [VAL_W-1:0] sq_moment;
    } fe_item_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] x);
        if ((&x[WIDE_W-1:VAL_W-1]) || ~(|x[WIDE_W-1:VAL_W-1]))
        begin
            return x[VAL_W-1:0];
        end
        else if (x[WIDE_W-1])
        begin
            return VAL_MIN;
        end
        else
        begin
            return VAL_MAX;
        end
    endfunction

endpackage

@@ rtl/aou_fifo.sv @@
// ---------------------------------------------------------------------------
// aou_fifo
// short word queue between the moment front end and the step back end
// ---------------------------------------------------------------------------
`include "adaptive_optimizer_update_top_assert.svh"

module aou_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  aou_pkg::fe_item_t     push_item,
    input  logic                  pop,
    output aou_pkg::fe_item_t     pop_item,
    output logic                  empty,
    output logic [aou_pkg::CNT_W-1:0] count
);

    aou_pkg::fe_item_t                 slot_reg [aou_pkg::FIFO_DEPTH];
    logic [aou_pkg::PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [aou_pkg::PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [aou_pkg::CNT_W-1:0]         count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + aou_pkg::PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + aou_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + aou_pkg::CNT_W'(push) - aou_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = slot_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

    `AOU_ASSERT_IMPLIES(a_fifo_no_overflow, push && !pop, count_reg != aou_pkg::CNT_W'(aou_pkg::FIFO_DEPTH), "queue overflow")
    `AOU_ASSERT_IMPLIES(a_fifo_no_underflow, pop, count_reg != '0, "queue underflow")

endmodule

@@ rtl/aou_front.sv @@
// ---------------------------------------------------------------------------
// aou_front
// accepts words, reads and updates the moment store, hands moments onward
// ---------------------------------------------------------------------------
`include "adaptive_optimizer_update_top_assert.svh"

module aou_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  aou_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [aou_pkg::IDX_W-1:0]         in_idx,
    input  logic signed [aou_pkg::VAL_W-1:0]  in_weight,
    input  logic signed [aou_pkg::VAL_W-1:0]  in_grad,
    input  logic [aou_pkg::CNT_W-1:0]         fifo_count,
    output logic                              push,
    output aou_pkg::fe_item_t                 push_item
);

    localparam int CLR_W = $clog2(aou_pkg::ENTRIES) + 1;
    localparam int AW    = $clog2(aou_pkg::ENTRIES);
    localparam int MEM_W = 2 * aou_pkg::VAL_W + 1;

    // store entry: seen flag, first moment, second moment
    logic [MEM_W-1:0] mem_reg [aou_pkg::ENTRIES];
    logic [MEM_W-1:0] rd_reg;

    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clearing;

    logic                              s1_valid_reg, s1_valid_next;
    logic [aou_pkg::IDX_W-1:0]         s1_idx_reg;
    logic signed [aou_pkg::VAL_W-1:0]  s1_weight_reg;
    logic signed [aou_pkg::VAL_W-1:0]  s1_grad_reg;
    logic                              s1_adaptive_reg;
    logic [2*aou_pkg::VAL_W-1:0]       s1_sqprod_reg, s1_sqprod_next;

    logic                              s2_valid_reg;
    logic [aou_pkg::IDX_W-1:0]         s2_idx_reg;
    logic signed [aou_pkg::VAL_W-1:0]  s2_weight_reg;
    logic signed [aou_pkg::VAL_W-1:0]  s2_grad_reg;
    logic signed [aou_pkg::VAL_W-1:0]  s2_sq_reg, s2_sq_next;
    logic                              s2_adaptive_reg;
    logic                              s2_seen_reg;
    logic signed [48:0]                s2_p1_reg, s2_p1_next, s2_p3_reg, s2_p3_next;
    logic signed [49:0]                s2_p2_reg, s2_p2_next, s2_p4_reg, s2_p4_next;

    logic [aou_pkg::VAL_W-1:0]         abs_grad;
    logic [aou_pkg::DEC_W:0]           one_minus_d1, one_minus_d2;
    logic signed [aou_pkg::VAL_W-1:0]  old_m, old_s;
    logic signed [50:0]                sum_m, sum_s;
    logic signed [aou_pkg::VAL_W-1:0]  m_new, s_new;
    logic [aou_pkg::CNT_W:0]           occupancy;
    logic                              hazard, accept, mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [MEM_W-1:0]                  mem_wdata;

    // blend sum shifted down by 16 toward zero, then saturated
    function automatic logic signed [aou_pkg::VAL_W-1:0] blend_shift(
        input logic signed [50:0] sum);
        logic [50:0]                      mag;
        logic [34:0]                      shr;
        logic signed [aou_pkg::WIDE_W-1:0] val;
        mag = sum[50] ? 51'(-sum) : sum;
        shr = mag[50:16];
        val = sum[50] ? -$signed({23'b0, shr}) : $signed({23'b0, shr});
        return aou_pkg::sat_val(val);
    endfunction

    // clearing pass over the seen flags after reset
    assign clearing     = !clr_cnt_reg[CLR_W-1];
    assign clr_cnt_next = clearing ? clr_cnt_reg + CLR_W'(1) : clr_cnt_reg;

    assign occupancy = (aou_pkg::CNT_W+1)'(fifo_count) + (aou_pkg::CNT_W+1)'(s1_valid_reg)
                     + (aou_pkg::CNT_W+1)'(s2_valid_reg);
    assign hazard = cfg.update_mode &&
                    ((s1_valid_reg && s1_adaptive_reg && (s1_idx_reg == in_idx)) ||
                     (s2_valid_reg && s2_adaptive_reg && (s2_idx_reg == in_idx)));
    assign in_ready = !clearing && !hazard &&
                      (occupancy < (aou_pkg::CNT_W+1)'(aou_pkg::FIFO_DEPTH));
    assign accept   = in_valid && in_ready;

    // stage one: square of the gradient
    always_comb
    begin
        abs_grad       = in_grad[aou_pkg::VAL_W-1] ? aou_pkg::VAL_W'(-in_grad) : in_grad;
        s1_sqprod_next = (2*aou_pkg::VAL_W)'(abs_grad) * (2*aou_pkg::VAL_W)'(abs_grad);
        s1_valid_next  = accept;
    end

    // stage two: blend products against the stored moments
    always_comb
    begin
        one_minus_d1 = 17'h10000 - {1'b0, cfg.first_decay};
        one_minus_d2 = 17'h10000 - {1'b0, cfg.second_decay};
        old_m        = rd_reg[2*aou_pkg::VAL_W-1:aou_pkg::VAL_W];
        old_s        = rd_reg[aou_pkg::VAL_W-1:0];
        if (|s1_sqprod_reg[63:55])
        begin
            s2_sq_next = aou_pkg::VAL_MAX;
        end
        else
        begin
            s2_sq_next = {1'b0, s1_sqprod_reg[54:24]};
        end
        s2_p1_next = $signed({1'b0, cfg.first_decay}) * old_m;
        s2_p2_next = $signed({1'b0, one_minus_d1}) * s1_grad_reg;
        s2_p3_next = $signed({1'b0, cfg.second_decay}) * old_s;
        s2_p4_next = $signed({1'b0, one_minus_d2}) * s2_sq_next;
    end

    // stage three: new moments, store write, hand-off
    always_comb
    begin
        sum_m = $signed({{2{s2_p1_reg[48]}}, s2_p1_reg}) + $signed({s2_p2_reg[49], s2_p2_reg});
        sum_s = $signed({{2{s2_p3_reg[48]}}, s2_p3_reg}) + $signed({s2_p4_reg[49], s2_p4_reg});
        m_new = s2_seen_reg ? blend_shift(sum_m) : s2_grad_reg;
        s_new = s2_seen_reg ? blend_shift(sum_s) : s2_sq_reg;

        mem_we    = clearing || (s2_valid_reg && s2_adaptive_reg);
        mem_waddr = clearing ? clr_cnt_reg[AW-1:0] : s2_idx_reg;
        mem_wdata = clearing ? '0 : {1'b1, m_new, s_new};

        push                = s2_valid_reg;
        push_item.idx       = s2_idx_reg;
        push_item.weight    = s2_weight_reg;
        push_item.adaptive  = s2_adaptive_reg;
        push_item.moment    = s2_adaptive_reg ? m_new : s2_grad_reg;
        push_item.sq_moment = s2_adaptive_reg ? s_new : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg      <= in_idx;
        s1_weight_reg   <= in_weight;
        s1_grad_reg     <= in_grad;
        s1_adaptive_reg <= cfg.update_mode;
        s1_sqprod_reg   <= s1_sqprod_next;
        s2_idx_reg      <= s1_idx_reg;
        s2_weight_reg   <= s1_weight_reg;
        s2_grad_reg     <= s1_grad_reg;
        s2_sq_reg       <= s2_sq_next;
        s2_adaptive_reg <= s1_adaptive_reg;
        s2_seen_reg     <= rd_reg[MEM_W-1];
        s2_p1_reg       <= s2_p1_next;
        s2_p2_reg       <= s2_p2_next;
        s2_p3_reg       <= s2_p3_next;
        s2_p4_reg       <= s2_p4_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem_reg[in_idx];
    end

    `AOU_ASSERT_IMPLIES(a_front_idle_in_clear, clearing, !s1_valid_reg && !s2_valid_reg, "word in flight during clear")
    `AOU_ASSERT_IMPLIES(a_front_no_stale_read, accept && cfg.update_mode && s2_valid_reg && s2_adaptive_reg, s2_idx_reg != in_idx, "read before pending write")

endmodule

@@ rtl/aou_back.sv @@
// ---------------------------------------------------------------------------
// aou_back
// root, division and weight update pipeline with output register
// ---------------------------------------------------------------------------
`include "adaptive_optimizer_update_top_assert.svh"

module aou_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  aou_pkg::cfg_t                     cfg,
    input  logic                              fifo_empty,
    input  aou_pkg::fe_item_t                 fifo_item,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [aou_pkg::IDX_W-1:0]         out_idx,
    output logic signed [aou_pkg::VAL_W-1:0]  out_weight
);

    localparam int ROOT_W = aou_pkg::ROOT_W;
    localparam int RAD_W  = aou_pkg::RAD_W;
    localparam int NUM_W  = aou_pkg::NUM_W;

    typedef struct packed {
        logic [aou_pkg::IDX_W-1:0]        idx;
        logic signed [aou_pkg::VAL_W-1:0] weight;
        logic                             adaptive;
        logic                             neg;
        logic [NUM_W-1:0]                 prod;
        logic [RAD_W-1:0]                 rad;
        logic [ROOT_W+1:0]                rem;
        logic [ROOT_W-1:0]                root;
    } sq_t;

    typedef struct packed {
        logic [aou_pkg::IDX_W-1:0]        idx;
        logic signed [aou_pkg::VAL_W-1:0] weight;
        logic                             neg;
        logic [NUM_W-1:0]                 nq;
        logic [ROOT_W-1:0]                rem;
        logic [ROOT_W-1:0]                dsor;
    } dv_t;

    logic                              adv;
    logic                              b0_vld_reg, b0_vld_next;
    sq_t                               b0_reg, b0_next;
    logic [ROOT_W-1:0]                 sq_vld_reg, sq_vld_next;
    sq_t                               sq_reg [ROOT_W];
    sq_t                               sq_src [ROOT_W];
    logic [NUM_W-1:0]                  dv_vld_reg, dv_vld_next;
    dv_t                               dv_reg [NUM_W];
    dv_t                               dv_src [NUM_W];
    dv_t                               dv_first;
    logic                              out_valid_reg, out_valid_next;
    logic [aou_pkg::IDX_W-1:0]         out_idx_reg, out_idx_next;
    logic signed [aou_pkg::VAL_W-1:0]  out_weight_reg, out_weight_next;
    logic [aou_pkg::VAL_W-1:0]         abs_m;
    logic [aou_pkg::VAL_W-1:0]         s_plus1;
    logic signed [aou_pkg::WIDE_W-1:0] w_wide, q_wide;
    dv_t                               dv_last;

    // one root bit per stage
    function automatic sq_t sqrt_step(input sq_t a);
        sq_t              r;
        logic [ROOT_W+3:0] t, trial;
        logic             ge;
        r     = a;
        t     = {a.rem, a.rad[RAD_W-1 -: 2]};
        trial = {2'b00, a.root, 2'b01};
        ge    = (t >= trial);
        r.rem  = ge ? (ROOT_W+2)'(t - trial) : t[ROOT_W+1:0];
        r.root = {a.root[ROOT_W-2:0], ge};
        r.rad  = {a.rad[RAD_W-3:0], 2'b00};
        return r;
    endfunction

    // one quotient bit per stage, restoring
    function automatic dv_t div_step(input dv_t a);
        dv_t            r;
        logic [ROOT_W:0] t;
        logic           ge;
        r    = a;
        t    = {a.rem, a.nq[NUM_W-1]};
        ge   = (t >= {1'b0, a.dsor});
        r.rem = ge ? ROOT_W'(t - {1'b0, a.dsor}) : t[ROOT_W-1:0];
        r.nq  = {a.nq[NUM_W-2:0], ge};
        return r;
    endfunction

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !fifo_empty;

    // entry: step numerator and root radicand
    always_comb
    begin
        abs_m   = fifo_item.moment[aou_pkg::VAL_W-1] ? aou_pkg::VAL_W'(-fifo_item.moment)
                                                     : fifo_item.moment;
        s_plus1 = fifo_item.sq_moment + 32'd1;
        b0_next.idx      = fifo_item.idx;
        b0_next.weight   = fifo_item.weight;
        b0_next.adaptive = fifo_item.adaptive;
        b0_next.neg      = fifo_item.moment[aou_pkg::VAL_W-1];
        b0_next.prod     = NUM_W'(cfg.learning_rate) * NUM_W'(abs_m);
        b0_next.rad      = {s_plus1, {aou_pkg::FRAC_W{1'b0}}};
        b0_next.rem      = '0;
        b0_next.root     = '0;
        b0_vld_next      = adv ? pop : b0_vld_reg;
    end

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sq
        if (i == 0)
        begin : g_head
            assign sq_src[i] = b0_reg;
        end
        else
        begin : g_body
            assign sq_src[i] = sq_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[i] <= sqrt_step(sq_src[i]);
            end
        end
    end

    // plain mode divides by one in Q8.24, i.e. shifts right by 24
    always_comb
    begin
        dv_first.idx    = sq_reg[ROOT_W-1].idx;
        dv_first.weight = sq_reg[ROOT_W-1].weight;
        dv_first.neg    = sq_reg[ROOT_W-1].neg;
        dv_first.nq     = sq_reg[ROOT_W-1].prod;
        dv_first.rem    = '0;
        dv_first.dsor   = sq_reg[ROOT_W-1].adaptive ? sq_reg[ROOT_W-1].root
                                                    : ROOT_W'(1) << aou_pkg::FRAC_W;
    end

    for (genvar j = 0; j < NUM_W; j++)
    begin : g_dv
        if (j == 0)
        begin : g_head
            assign dv_src[j] = dv_first;
        end
        else
        begin : g_body
            assign dv_src[j] = dv_reg[j-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j] <= div_step(dv_src[j]);
            end
        end
    end

    always_comb
    begin
        sq_vld_next = adv ? {sq_vld_reg[ROOT_W-2:0], b0_vld_reg} : sq_vld_reg;
        dv_vld_next = adv ? {dv_vld_reg[NUM_W-2:0], sq_vld_reg[ROOT_W-1]} : dv_vld_reg;
        dv_last     = dv_reg[NUM_W-1];
        w_wide      = aou_pkg::WIDE_W'(dv_last.weight);
        q_wide      = $signed({2'b00, dv_last.nq});
        out_valid_next  = adv ? dv_vld_reg[NUM_W-1] : out_valid_reg;
        out_idx_next    = adv ? dv_last.idx : out_idx_reg;
        out_weight_next = adv ? aou_pkg::sat_val(dv_last.neg ? w_wide + q_wide : w_wide - q_wide)
                              : out_weight_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_vld_reg    <= 1'b0;
            sq_vld_reg    <= '0;
            dv_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b0_vld_reg    <= b0_vld_next;
            sq_vld_reg    <= sq_vld_next;
            dv_vld_reg    <= dv_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_reg <= b0_next;
        end
        out_idx_reg    <= out_idx_next;
        out_weight_reg <= out_weight_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_idx    = out_idx_reg;
    assign out_weight = out_weight_reg;

    `AOU_ASSERT_IMPLIES(a_back_divisor_nonzero, sq_vld_reg[ROOT_W-1], dv_first.dsor != '0, "zero divisor")

endmodule

@@ rtl/adaptive_optimizer_update_top.sv @@
// ---------------------------------------------------------------------------
// adaptive_optimizer_update_top
// adam style optimizer step per parameter element, fixed point Q8.24
// ---------------------------------------------------------------------------
// usage
//   s_* : one word per parameter element (index, weight, gradient)
//   m_* : one word per element (index, updated weight), same order
//   cfg_* : register writes, index 0 mode, 1 rate, 2 first decay,
//           3 second decay; cfg_ready is always high, write only when idle
// throughput: one word per cycle while s_tready is high; an adaptive word
//   whose index is still in the two-stage moment update stalls s_tready
// pipeline: the back end holds a 28 stage root and a 56 stage
//   divider before its output register
// reset: the seen flags of all 4096 entries are swept clear after reset,
//   s_tready stays low during that pass; registers return to defaults
// stall: a low m_tready freezes the back pipeline; the front keeps taking
//   words until the 8 word queue and its two stages together hold 8 words
// ---------------------------------------------------------------------------
module adaptive_optimizer_update_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // param_index [11:0], weight_in [43:12], grad_in [75:44], zero fill
    input  logic [79:0]                        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // param_index_out [11:0], weight_out [43:12], zero fill
    output logic [47:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aou_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aou_pkg::CFG_DATA_W-1:0]     cfg_data
);

    aou_pkg::cfg_t                     cfg_reg, cfg_next;
    logic                              push, pop, fifo_empty;
    aou_pkg::fe_item_t                 push_item, pop_item;
    logic [aou_pkg::CNT_W-1:0]         fifo_count;
    logic [aou_pkg::IDX_W-1:0]         out_idx;
    logic signed [aou_pkg::VAL_W-1:0]  out_weight;

    assign cfg_ready = 1'b1;

    // register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (aou_pkg::cfg_reg_t'(cfg_index))
                aou_pkg::REG_UPDATE_MODE:   cfg_next.update_mode   = cfg_data[0];
                aou_pkg::REG_LEARNING_RATE: cfg_next.learning_rate = cfg_data[aou_pkg::LR_W-1:0];
                aou_pkg::REG_FIRST_DECAY:   cfg_next.first_decay   = cfg_data[aou_pkg::DEC_W-1:0];
                aou_pkg::REG_SECOND_DECAY:  cfg_next.second_decay  = cfg_data[aou_pkg::DEC_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_mode   <= aou_pkg::RST_UPDATE_MODE;
            cfg_reg.learning_rate <= aou_pkg::RST_LEARNING_RATE;
            cfg_reg.first_decay   <= aou_pkg::RST_FIRST_DECAY;
            cfg_reg.second_decay  <= aou_pkg::RST_SECOND_DECAY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept, moment read-modify-write
    aou_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_idx     (s_tdata[11:0]),
        .in_weight  (s_tdata[43:12]),
        .in_grad    (s_tdata[75:44]),
        .fifo_count (fifo_count),
        .push       (push),
        .push_item  (push_item)
    );

    // queue decoupling the two halves
    aou_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty),
        .count     (fifo_count)
    );

    // back: root, divide, weight update
    aou_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .fifo_item  (pop_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_idx    (out_idx),
        .out_weight (out_weight)
    );

    assign m_tdata = {4'b0000, out_weight, out_idx};

endmodule
